// ===== rtl/msbbr_pkg.sv =====
package msbbr_pkg;

  // Field and register widths.
  localparam int unsigned OpW     = 3;
  localparam int unsigned AddrW   = 12;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CntW    = 10;
  localparam int unsigned ValW    = 64;
  localparam int unsigned PosW    = 16;
  localparam int unsigned CfgW    = 13;
  localparam int unsigned LimW    = PosW + 1;
  localparam int unsigned RemW    = 7;
  localparam int unsigned NBytesW = 7;

  // Read length limits.
  localparam int unsigned MaxReadBits     = 64;
  localparam int unsigned MaxByteReadBits = 512;

  // Default buffer capacity in bytes.
  localparam int unsigned BufBytesDefault = 4096;

  // Highest read position.
  localparam logic [PosW-1:0] PosTop = {PosW{1'b1}};

  // Operation codes.
  localparam logic [OpW-1:0] OP_WRITE   = 3'd0;
  localparam logic [OpW-1:0] OP_RESTART = 3'd1;
  localparam logic [OpW-1:0] OP_READ    = 3'd2;
  localparam logic [OpW-1:0] OP_BYTES   = 3'd3;
  localparam logic [OpW-1:0] OP_ALIGN   = 3'd4;
  localparam logic [OpW-1:0] OP_SKIP    = 3'd5;

  // Request to the bit extraction step.
  typedef struct packed {
    logic [PosW-1:0] pos;
    logic [RemW-1:0] rem;
    logic [LimW-1:0] limit;
  } step_in_t;

  // Outcome of one bit extraction step.
  typedef struct packed {
    logic [PosW-1:0] pos_next;
    logic [RemW-1:0] rem_next;
    logic            done;
  } step_out_t;

endpackage

// ===== rtl/msbbr_buf_mem.sv =====
module msbbr_buf_mem #(
  parameter int unsigned BUF_BYTES = 4096,
  parameter int unsigned AW        = 12
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem_q [BUF_BYTES];
  logic [7:0] rd_data_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/msbbr_step.sv =====
module msbbr_step
  import msbbr_pkg::*;
(
  input  step_in_t             step_i,
  input  logic [ByteW-1:0]     byte_i,
  input  logic [ValW-1:0]      acc_i,
  output logic [ValW-1:0]      acc_o,
  output step_out_t            step_o
);

  logic [3:0]      avail;
  logic [LimW-1:0] pos_ext;
  logic [LimW-1:0] to_lim;
  logic [3:0]      to_lim8;
  logic [3:0]      rem8;
  logic [3:0]      k;
  logic [3:0]      shamt;
  logic [8:0]      mask9;
  logic [7:0]      bits;
  logic [LimW-1:0] pos_next_ext;

  // Take as many bits as the byte, the request and the end allow.
  always_comb begin
    avail   = 4'd8 - {1'b0, step_i.pos[2:0]};
    pos_ext = {1'b0, step_i.pos};
    to_lim  = (pos_ext >= step_i.limit) ? '0 : step_i.limit - pos_ext;
    to_lim8 = (to_lim > LimW'(8)) ? 4'd8 : to_lim[3:0];
    rem8    = (step_i.rem > RemW'(8)) ? 4'd8 : step_i.rem[3:0];
    k       = avail;
    if (rem8 < k) begin
      k = rem8;
    end
    if (to_lim8 < k) begin
      k = to_lim8;
    end
    shamt = avail - k;
    mask9 = (9'd1 << k) - 9'd1;
    bits  = (byte_i >> shamt) & mask9[7:0];
  end

  // Append the bits and advance the position.
  always_comb begin
    acc_o           = (acc_i << k) | ValW'(bits);
    step_o.pos_next = step_i.pos + PosW'(k);
    step_o.rem_next = step_i.rem - RemW'(k);
    pos_next_ext    = {1'b0, step_o.pos_next};
    step_o.done     = (step_o.rem_next == '0) || (pos_next_ext >= step_i.limit);
  end

endmodule

// ===== rtl/msb_first_bit_reader_unit.sv =====
// MSB-first bit reader over a byte buffer.
// Requests enter on the in_valid_i/in_ready_o channel; results leave on the
// out_valid_o/out_ready_i channel through one output register. The buffer
// length is written on the cfg channel, which is always ready.
// Write, restart, align, skip and unused codes are accepted when ready, and
// their single result is valid on the next cycle.
// A bit read or byte read walks the buffer one byte per cycle, unless held by
// a stalled receiver, through a shared extraction step fed by the registered
// memory read port. A byte read gives one result for each output byte; an
// output byte that straddles two buffer bytes is gathered from both in turn.
// The block takes no new request while a read is under way, and the next
// request only when the output register is free or being emptied.
// When the receiver stalls, the read holds at its current byte until the
// output register drains.
// Reset clears the read position and the buffer length; buffer contents are
// undefined until written, and no clearing pass runs.
module msb_first_bit_reader_unit
  import msbbr_pkg::*;
#(
  parameter int unsigned BUF_BYTES = BufBytesDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CfgW-1:0]  cfg_buffer_bytes_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [OpW-1:0]   op_i,
  input  logic [AddrW-1:0] byte_address_i,
  input  logic [ByteW-1:0] byte_value_i,
  input  logic [CntW-1:0]  bit_count_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ValW-1:0]  value_o,
  output logic             last_o,
  output logic [PosW-1:0]  bit_position_o,
  output logic             at_end_o
);

  localparam int unsigned AW    = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
  localparam int unsigned IdxW  = 14;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                 state_q, state_d;
  logic [PosW-1:0]      pos_q, pos_d;
  logic [RemW-1:0]      rem_q, rem_d;
  logic [ValW-1:0]      acc_q, acc_d;
  logic                 bytes_q, bytes_d;
  logic [NBytesW-1:0]   left_q, left_d;
  logic [2:0]           tail_q, tail_d;
  logic [CfgW-1:0]      bb_q;

  logic                 out_valid_q, out_valid_d;
  logic [ValW-1:0]      value_q, value_d;
  logic                 last_q, last_d;
  logic [PosW-1:0]      opos_q, opos_d;
  logic                 at_end_q, at_end_d;

  logic [CfgW-1:0]      bb_sat;
  logic [LimW-1:0]      end_bits;
  logic [LimW-1:0]      limit;
  logic                 out_free;
  logic                 accept;

  logic [IdxW-1:0]      wr_idx;
  logic                 wr_en;
  logic [IdxW-1:0]      rd_idx;
  logic [AW-1:0]        rd_addr;
  logic [ByteW-1:0]     rd_data;

  step_in_t             step_in;
  step_out_t            step_out;
  logic [ValW-1:0]      acc_next;

  logic [LimW-1:0]      sum;
  logic [CntW-1:0]      cnt_rd;
  logic [CntW-1:0]      cnt_by;
  logic [CntW:0]        nbytes_sum;
  logic [NBytesW-1:0]   nbytes;
  logic [3:0]           unit_bits;
  logic [7:0]           byte_out;

  // Buffer length clamped to capacity, and the end as a bit position.
  always_comb begin
    bb_sat   = (IdxW'(bb_q) > IdxW'(BUF_BYTES)) ? CfgW'(BUF_BYTES) : bb_q;
    end_bits = {1'b0, bb_sat, 3'b000};
    limit    = (end_bits > LimW'(PosTop)) ? LimW'(PosTop) : end_bits;
  end

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE) && out_free;
  assign accept      = in_valid_i && in_ready_o;

  // Buffer length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bb_q <= '0;
    end else if (cfg_valid_i) begin
      bb_q <= cfg_buffer_bytes_i;
    end
  end

  // Byte writes go straight to the memory.
  assign wr_idx = IdxW'(byte_address_i);
  assign wr_en  = accept && (op_i == OP_WRITE) && (wr_idx < IdxW'(BUF_BYTES));

  // The memory always fetches the byte under the next position.
  assign rd_idx  = IdxW'(pos_d[PosW-1:3]);
  assign rd_addr = (rd_idx < IdxW'(BUF_BYTES)) ? rd_idx[AW-1:0] : '0;

  msbbr_buf_mem #(
    .BUF_BYTES (BUF_BYTES),
    .AW        (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_idx[AW-1:0]),
    .wr_data_i (byte_value_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Shared extraction step.
  assign step_in.pos   = pos_q;
  assign step_in.rem   = rem_q;
  assign step_in.limit = limit;

  msbbr_step u_step (
    .step_i (step_in),
    .byte_i (rd_data),
    .acc_i  (acc_q),
    .acc_o  (acc_next),
    .step_o (step_out)
  );

  // Request decode helpers.
  always_comb begin
    cnt_rd     = (bit_count_i > CntW'(MaxReadBits)) ? CntW'(MaxReadBits) : bit_count_i;
    cnt_by     = (bit_count_i > CntW'(MaxByteReadBits)) ? CntW'(MaxByteReadBits)
                                                         : bit_count_i;
    nbytes_sum = {1'b0, cnt_by} + (CntW+1)'(7);
    nbytes     = NBytesW'(nbytes_sum >> 3);
    unit_bits  = ((left_q == NBytesW'(1)) && (tail_q != '0)) ? {1'b0, tail_q} : 4'd8;
    byte_out   = acc_next[7:0] << (4'd8 - unit_bits);
  end

  // Sequencer and result formation.
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    rem_d       = rem_q;
    acc_d       = acc_q;
    bytes_d     = bytes_q;
    left_d      = left_q;
    tail_d      = tail_q;
    out_valid_d = out_valid_q && !out_ready_i;
    value_d     = value_q;
    last_d      = last_q;
    opos_d      = opos_q;
    at_end_d    = at_end_q;
    sum         = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_i)
            OP_RESTART: pos_d = '0;
            OP_ALIGN: begin
              if (pos_q[2:0] != 3'b000) begin
                sum   = {1'b0, pos_q} + LimW'(4'd8 - {1'b0, pos_q[2:0]});
                pos_d = (sum > LimW'(PosTop)) ? PosTop : sum[PosW-1:0];
              end
            end
            OP_SKIP: begin
              sum   = {1'b0, pos_q} + LimW'(bit_count_i);
              pos_d = (sum > LimW'(PosTop)) ? PosTop : sum[PosW-1:0];
            end
            default: pos_d = pos_q;
          endcase

          if (op_i == OP_READ) begin
            state_d = ST_RUN;
            bytes_d = 1'b0;
            rem_d   = RemW'(cnt_rd);
            acc_d   = '0;
          end else if (op_i == OP_BYTES) begin
            // A zero-length byte read gives no result at all.
            if (cnt_by != '0) begin
              state_d = ST_RUN;
              bytes_d = 1'b1;
              left_d  = nbytes;
              tail_d  = cnt_by[2:0];
              rem_d   = ((nbytes == NBytesW'(1)) && (cnt_by[2:0] != 3'b000))
                        ? RemW'(cnt_by[2:0]) : RemW'(8);
              acc_d   = '0;
            end
          end else begin
            out_valid_d = 1'b1;
            value_d     = '0;
            last_d      = 1'b1;
            opos_d      = pos_d;
            at_end_d    = {1'b0, pos_d} >= end_bits;
          end
        end
      end

      ST_RUN: begin
        if (!step_out.done) begin
          // The step used the whole byte; continue at the next one.
          pos_d = step_out.pos_next;
          rem_d = step_out.rem_next;
          acc_d = acc_next;
        end else if (out_free) begin
          pos_d       = step_out.pos_next;
          out_valid_d = 1'b1;
          opos_d      = step_out.pos_next;
          at_end_d    = {1'b0, step_out.pos_next} >= end_bits;
          if (!bytes_q) begin
            value_d = acc_next;
            last_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            value_d = ValW'(byte_out);
            last_d  = (left_q == NBytesW'(1));
            left_d  = left_q - NBytesW'(1);
            acc_d   = '0;
            rem_d   = ((left_q == NBytesW'(2)) && (tail_q != 3'b000))
                      ? RemW'(tail_q) : RemW'(8);
            if (left_q == NBytesW'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result payload.
  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    acc_q    <= acc_d;
    bytes_q  <= bytes_d;
    left_q   <= left_d;
    tail_q   <= tail_d;
    value_q  <= value_d;
    last_q   <= last_d;
    opos_q   <= opos_d;
    at_end_q <= at_end_d;
  end

  assign out_valid_o    = out_valid_q;
  assign value_o        = value_q;
  assign last_o         = last_q;
  assign bit_position_o = opos_q;
  assign at_end_o       = at_end_q;

endmodule
